@@ rtl/uvr_pkg.sv @@
// ----------------------------------------------------------------------------
// uvr_pkg
// Types, constants and byte classifiers shared by the utf-8 repair block.
// ----------------------------------------------------------------------------
`default_nettype none

package uvr_pkg;

   // input word: one raw byte of the string
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_string;
   } req_type;

   // output word: one byte of the repaired string
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_done;
      logic       string_valid;
   } rsp_type;

   // how the back end expands one byte of a command
   localparam logic [1:0] KIND_PASS   = 2'd0;
   localparam logic [1:0] KIND_UNDER  = 2'd1;
   localparam logic [1:0] KIND_LATIN1 = 2'd2;

   localparam int unsigned CMD_SLOTS = 4;
   localparam int unsigned PEND_DEPTH = 3;

   // configuration register indexes
   localparam logic [1:0] CSR_PATH_MODE     = 2'd0;
   localparam logic [1:0] CSR_WINDOWS_CHARS = 2'd1;

   localparam logic [7:0] UNDERSCORE = 8'h5f;

   // one work unit handed from the front end to the back end
   typedef struct packed {
      logic [CMD_SLOTS-1:0][7:0] bytes;
      logic [CMD_SLOTS-1:0][1:0] kinds;
      logic [1:0]                last_slot;
      logic                      eos;
      logic                      valid;
   } cmd_type;

   // sequence length implied by a lead byte, zero if not a lead
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd0;
      if ((b & 8'he0) == 8'hc0) begin
         len = 3'd2;
      end else if ((b & 8'hf0) == 8'he0) begin
         len = 3'd3;
      end else if ((b & 8'hf8) == 8'hf0) begin
         len = 3'd4;
      end
      return len;
   endfunction

   function automatic logic path_bad(input logic [7:0] b, input logic pm,
                                     input logic wc);
      logic bad;
      bad = 1'b0;
      if (pm) begin
         if (b < 8'd32) begin
            bad = 1'b1;
         end else if (wc) begin
            bad = (b == 8'h3f) || (b == 8'h3c) || (b == 8'h3e) || (b == 8'h22) ||
                  (b == 8'h7c) || (b == 8'h2a) || (b == 8'h3a);
         end
      end
      return bad;
   endfunction

endpackage

`default_nettype wire

@@ rtl/uvr_front.sv @@
// ----------------------------------------------------------------------------
// uvr_front
// Classifies each input byte against the held sequence and issues commands.
// ----------------------------------------------------------------------------
`default_nettype none

module uvr_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire uvr_pkg::req_type req_data,
   input  wire logic            csr_valid,
   input  wire logic [1:0]      csr_index,
   input  wire logic            csr_wdata,
   output      logic            cmd_push,
   output      uvr_pkg::cmd_type cmd_data
);

   logic [7:0] pend_ff [uvr_pkg::PEND_DEPTH];
   logic [2:0] pend_we;
   logic [1:0] cnt_ff, cnt_in;
   logic       all_valid_ff, all_valid_in;
   logic       path_mode_ff, path_mode_in;
   logic       windows_ff, windows_in;

   logic [7:0] b;
   logic       eos, is_cont, ascii, bad, fresh_store, fresh_emit, fresh_clear;
   logic [1:0] fresh_kind, pend_kind, b_kind;
   logic       b_emit, pend_emit, clear, valid_after;
   logic [2:0] need, p1, n_items;

   always_comb begin
      b           = req_data.in_byte;
      eos         = req_data.end_of_string;
      is_cont     = (b[7:6] == 2'b10);
      need        = uvr_pkg::lead_len(pend_ff[0]);
      p1          = {1'b0, cnt_ff} + 3'd1;
      ascii       = ~b[7];
      bad         = uvr_pkg::path_bad(b, path_mode_ff, windows_ff);
      fresh_store = ~ascii && (uvr_pkg::lead_len(b) != 3'd0) && ~eos;
      fresh_emit  = ~fresh_store;
      fresh_clear = ascii ? bad : ~fresh_store;
      fresh_kind  = ascii ? (bad ? uvr_pkg::KIND_UNDER : uvr_pkg::KIND_PASS)
                          : uvr_pkg::KIND_LATIN1;

      pend_kind = uvr_pkg::KIND_LATIN1;
      b_kind    = fresh_kind;
      b_emit    = fresh_emit;
      pend_emit = (cnt_ff != 2'd0);
      clear     = fresh_clear;
      pend_we   = 3'b000;
      cnt_in    = cnt_ff;

      priority if (cnt_ff != 2'd0 && is_cont && p1 == need) begin
         // sequence complete, pass all of it
         pend_kind = uvr_pkg::KIND_PASS;
         b_kind    = uvr_pkg::KIND_PASS;
         b_emit    = 1'b1;
         clear     = 1'b0;
         cnt_in    = 2'd0;
      end else if (cnt_ff != 2'd0 && is_cont && (eos || p1 > need)) begin
         b_kind = uvr_pkg::KIND_LATIN1;
         b_emit = 1'b1;
         clear  = 1'b1;
         cnt_in = 2'd0;
      end else if (cnt_ff != 2'd0 && is_cont) begin
         // hold another continuation byte
         pend_emit = 1'b0;
         b_emit    = 1'b0;
         clear     = 1'b0;
         cnt_in    = cnt_ff + 2'd1;
         unique case (cnt_ff)
            2'd1:    pend_we = 3'b010;
            2'd2:    pend_we = 3'b100;
            default: pend_we = 3'b000;
         endcase
      end else begin
         // broken or no sequence: flush held bytes, scan this one fresh
         clear   = fresh_clear || (cnt_ff != 2'd0);
         pend_we = {2'b00, fresh_store};
         cnt_in  = fresh_store ? 2'd1 : 2'd0;
      end
      if (eos) begin
         cnt_in = 2'd0;
      end

      valid_after  = all_valid_ff & ~clear;
      all_valid_in = eos ? 1'b1 : valid_after;
      n_items      = (pend_emit ? {1'b0, cnt_ff} : 3'd0) + {2'b00, b_emit};

      for (int k = 0; k < uvr_pkg::CMD_SLOTS; k++) begin
         if (k < int'(cnt_ff)) begin
            cmd_data.bytes[k] = pend_ff[k % uvr_pkg::PEND_DEPTH];
            cmd_data.kinds[k] = pend_kind;
         end else begin
            cmd_data.bytes[k] = b;
            cmd_data.kinds[k] = b_kind;
         end
      end
      cmd_data.last_slot = 2'(n_items - 3'd1);
      cmd_data.eos       = eos;
      cmd_data.valid     = valid_after;
      cmd_push           = accept && (pend_emit || b_emit);
   end

   always_comb begin
      path_mode_in = path_mode_ff;
      windows_in   = windows_ff;
      if (csr_valid && csr_index == uvr_pkg::CSR_PATH_MODE) begin
         path_mode_in = csr_wdata;
      end
      if (csr_valid && csr_index == uvr_pkg::CSR_WINDOWS_CHARS) begin
         windows_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= 2'd0;
         all_valid_ff <= 1'b1;
         path_mode_ff <= 1'b0;
         windows_ff   <= 1'b0;
      end else begin
         path_mode_ff <= path_mode_in;
         windows_ff   <= windows_in;
         if (accept) begin
            cnt_ff       <= cnt_in;
            all_valid_ff <= all_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < uvr_pkg::PEND_DEPTH; k++) begin
         if (accept && pend_we[k]) begin
            pend_ff[k] <= b;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/uvr_cmdq.sv @@
// ----------------------------------------------------------------------------
// uvr_cmdq
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module uvr_cmdq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire uvr_pkg::cmd_type push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic             empty,
   output      uvr_pkg::cmd_type head
);

   uvr_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && ~full;
   assign do_pop  = pop && ~empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/uvr_back.sv @@
// ----------------------------------------------------------------------------
// uvr_back
// Expands commands into output bytes, one per cycle while the output register is free or popped.
// ----------------------------------------------------------------------------
`default_nettype none

module uvr_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_valid,
   input  wire uvr_pkg::cmd_type cmd,
   output      logic             cmd_pop,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      uvr_pkg::rsp_type rsp_data
);

   logic [1:0]       slot_ff, slot_in;
   logic             half_ff, half_in;
   logic             out_valid_ff, out_valid_in;
   uvr_pkg::rsp_type out_ff, out_in;

   logic       adv, slot_last, cmd_last;
   logic [7:0] cur_byte;
   logic [1:0] cur_kind;

   always_comb begin
      adv      = cmd_valid && (~out_valid_ff || rsp_pop);
      cur_byte = cmd.bytes[slot_ff];
      cur_kind = cmd.kinds[slot_ff];

      unique case (cur_kind)
         uvr_pkg::KIND_UNDER: begin
            out_in.out_byte = uvr_pkg::UNDERSCORE;
            slot_last       = 1'b1;
         end
         uvr_pkg::KIND_LATIN1: begin
            // two-byte encoding of the byte taken as latin-1
            out_in.out_byte = half_ff ? {2'b10, cur_byte[5:0]}
                                      : {6'b110000, cur_byte[7:6]};
            slot_last       = half_ff;
         end
         default: begin
            out_in.out_byte = cur_byte;
            slot_last       = 1'b1;
         end
      endcase

      cmd_last            = slot_last && (slot_ff == cmd.last_slot);
      out_in.run_last     = cmd_last;
      out_in.string_done  = cmd_last && cmd.eos;
      out_in.string_valid = cmd_last && cmd.eos && cmd.valid;
      cmd_pop             = adv && cmd_last;

      slot_in = slot_ff;
      half_in = half_ff;
      if (adv) begin
         if (cmd_last) begin
            slot_in = 2'd0;
            half_in = 1'b0;
         end else if (slot_last) begin
            slot_in = slot_ff + 2'd1;
            half_in = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end

      out_valid_in = adv ? 1'b1 : (rsp_pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= 2'd0;
         half_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         half_ff      <= half_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;

   // second half of a latin-1 pair only while that command is at the head
   a_half_latin1: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (cmd_valid && cur_kind == uvr_pkg::KIND_LATIN1))
      else $error("second half pending without a latin-1 slot");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (slot_ff <= cmd.last_slot))
      else $error("slot index beyond the command");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (adv && cmd_last) |=> (slot_ff == 2'd0 && !half_ff))
      else $error("back end did not restart after a command");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.string_done) |-> out_ff.run_last)
      else $error("string end flagged on a word that is not a run end");

endmodule

`default_nettype wire

@@ rtl/utf8_validate_repair.sv @@
// ----------------------------------------------------------------------------
// utf8_validate_repair
// UTF-8 validator with latin-1 repair of broken bytes and path filtering.
//
//   channel  ports                                       handshake
//   req      req_push, req_full, req_data                push & !full
//   rsp      rsp_empty, rsp_pop, rsp_data                pop & !empty
//   csr      csr_valid, csr_ready, csr_index, csr_wdata  valid & ready
//
// One output word leaves per cycle while the consumer pops; an input byte makes
// zero to eight words, two in the steady worst case, so the output limits input.
// The output register and the back end's byte counter set the output pace.
// The front end takes a byte every cycle while the two-entry queue has room.
// Synchronous reset clears the held sequence, queue and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_validate_repair (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output      logic             req_full,
   input  wire uvr_pkg::req_type req_data,
   output      logic             rsp_empty,
   input  wire logic             rsp_pop,
   output      uvr_pkg::rsp_type rsp_data,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic             csr_wdata
);

   logic             accept, cmd_push, cmd_pop, cmdq_empty;
   uvr_pkg::cmd_type cmd_in, cmd_head;

   assign csr_ready = 1'b1;
   assign accept    = req_push && ~req_full;

   uvr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in)
   );

   uvr_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (req_full),
      .pop       (cmd_pop),
      .empty     (cmdq_empty),
      .head      (cmd_head)
   );

   uvr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (~cmdq_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the utf-8 validate and repair block. Byte strings
// are queued by the stimulus process, pushed by a clocked driver and
// predicted when each word is accepted. A clocked monitor pops repaired words
// and compares every field against the oldest predicted word. Phases cover
// each path mode setting under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // register indexes that the block ignores
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASE_WORDS = 14;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      uvr_pkg::req_type word;
      logic             wait_drain;
   } byte_item_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   uvr_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   uvr_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic             csr_wdata = 1'b0;

   // stimulus and scoreboard
   byte_item_type    send_q[$];
   byte_item_type    next_item;
   uvr_pkg::rsp_type repaired_q[$];
   uvr_pkg::rsp_type step_words[$];
   bit               push_taken = 1'b0;
   int               send_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               words_in = 0;
   int               words_out = 0;
   int               strings_sent = 0;
   int               csr_writes = 0;
   int               mismatches = 0;

   // predictor state
   logic [7:0] held_bytes[3];
   int         held_count = 0;
   logic       string_ok = 1'b1;
   logic       path_mode_r = 1'b0;
   logic       win_chars_r = 1'b0;

   utf8_validate_repair u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      casez (b)
         8'b110?????: return 3'd2;
         8'b1110????: return 3'd3;
         8'b11110???: return 3'd4;
         default:     return 3'd0;
      endcase
   endfunction

   function automatic logic bad_in_path(input logic [7:0] b);
      if (!path_mode_r) return 1'b0;
      if (b < 8'd32) return 1'b1;
      if (!win_chars_r) return 1'b0;
      return b == 8'h3f || b == 8'h3c || b == 8'h3e || b == 8'h22 ||
             b == 8'h7c || b == 8'h2a || b == 8'h3a;
   endfunction

   task automatic emit(input logic [7:0] b);
      uvr_pkg::rsp_type r;
      r = '0;
      r.out_byte = b;
      step_words.insert(step_words.size(), r);
   endtask

   task automatic emit_latin1(input logic [7:0] b);
      emit(8'hc0 | (b >> 6));
      emit(8'h80 | (b & 8'h3f));
      string_ok = 1'b0;
   endtask

   task automatic flush_held();
      for (int k = 0; k < held_count; k++) emit_latin1(held_bytes[k]);
      held_count = 0;
   endtask

   task automatic scan_fresh(input logic [7:0] b, input logic eos);
      if (b < 8'h80) begin
         if (bad_in_path(b)) begin
            emit(uvr_pkg::UNDERSCORE);
            string_ok = 1'b0;
         end else begin
            emit(b);
         end
      end else if (seq_len(b) == 3'd0 || eos) begin
         emit_latin1(b);
      end else begin
         held_bytes[0] = b;
         held_count = 1;
      end
   endtask

   task automatic predict_repair(input uvr_pkg::req_type w);
      logic [7:0] b;
      logic       eos;
      int         need;
      int         last;
      b = w.in_byte;
      eos = w.end_of_string;
      step_words.delete();
      if (held_count > 0) begin
         need = seq_len(held_bytes[0]);
         if (b[7:6] == 2'b10) begin
            if (held_count + 1 == need) begin
               for (int k = 0; k < held_count; k++) emit(held_bytes[k]);
               emit(b);
               held_count = 0;
            end else if (eos || held_count + 1 > need) begin
               flush_held();
               emit_latin1(b);
            end else begin
               held_bytes[held_count] = b;
               held_count++;
            end
         end else begin
            flush_held();
            scan_fresh(b, eos);
         end
      end else begin
         scan_fresh(b, eos);
      end
      if (step_words.size() > 0) begin
         last = step_words.size() - 1;
         step_words[last].run_last = 1'b1;
         if (eos) begin
            step_words[last].string_done = 1'b1;
            step_words[last].string_valid = string_ok;
         end
      end
      foreach (step_words[i]) repaired_q.insert(repaired_q.size(), step_words[i]);
      if (eos) begin
         held_count = 0;
         string_ok = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         predict_repair(req_data);
         push_taken = 1'b1;
         words_in++;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_push || push_taken)) begin
         push_taken = 1'b0;
         if (send_q.size() > 0 && $urandom_range(99) >= send_idle_pct &&
             !(send_q[0].wait_drain && repaired_q.size() != 0)) begin
            next_item = send_q.pop_front();
            req_data <= next_item.word;
            req_push <= 1'b1;
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic flag_error(input string what, input uvr_pkg::rsp_type want,
                             input uvr_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%s: expected byte %02h last %b done %b valid %b,",
                  what, want.out_byte, want.run_last, want.string_done, want.string_valid);
         $display("   got byte %02h last %b done %b valid %b",
                  got.out_byte, got.run_last, got.string_done, got.string_valid);
      end
   endtask

   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      uvr_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         words_out++;
         if (repaired_q.size() == 0) begin
            flag_error("unexpected word", '0, rsp_data);
         end else begin
            want = repaired_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.run_last !== want.run_last ||
                rsp_data.string_done !== want.string_done ||
                rsp_data.string_valid !== want.string_valid) begin
               flag_error("mismatch", want, rsp_data);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic csr_write(input logic [1:0] idx, input logic val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == uvr_pkg::CSR_PATH_MODE) path_mode_r = val;
      else if (idx == uvr_pkg::CSR_WINDOWS_CHARS) win_chars_r = val;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_byte(input logic [7:0] b, input logic eos, input logic drain = 1'b0);
      byte_item_type it;
      it.word.in_byte = b;
      it.word.end_of_string = eos;
      it.wait_drain = drain;
      send_q.insert(send_q.size(), it);
      if (eos) strings_sent++;
   endtask

   task automatic add_lead(input int len, inout logic [7:0] bytes[$]);
      case (len)
         2:       bytes.insert(bytes.size(), {3'b110, 5'($urandom)});
         3:       bytes.insert(bytes.size(), {4'b1110, 4'($urandom)});
         default: bytes.insert(bytes.size(), {5'b11110, 3'($urandom)});
      endcase
   endtask

   // mostly well-formed sequences, some path characters, broken runs and noise
   task automatic add_random_string(input logic drain, output int count);
      logic [7:0] bytes[$];
      int         parts;
      int         kind;
      int         len;
      int         conts;
      parts = $urandom_range(1, 6);
      for (int p = 0; p < parts; p++) begin
         kind = $urandom_range(99);
         if (kind < 35) begin
            case ($urandom_range(11))
               0:       bytes.insert(bytes.size(), 8'h3f);
               1:       bytes.insert(bytes.size(), 8'h3c);
               2:       bytes.insert(bytes.size(), 8'h3e);
               3:       bytes.insert(bytes.size(), 8'h22);
               4:       bytes.insert(bytes.size(), 8'h7c);
               5:       bytes.insert(bytes.size(), 8'h2a);
               6:       bytes.insert(bytes.size(), 8'h3a);
               7:       bytes.insert(bytes.size(), 8'h7f);
               8:       bytes.insert(bytes.size(), 8'($urandom_range(31)));
               default: bytes.insert(bytes.size(), 8'($urandom_range(127)));
            endcase
         end else if (kind < 75) begin
            len = $urandom_range(2, 4);
            add_lead(len, bytes);
            for (int k = 1; k < len; k++) bytes.insert(bytes.size(), {2'b10, 6'($urandom)});
         end else if (kind < 90) begin
            len = $urandom_range(2, 4);
            conts = $urandom_range(0, len - 2);
            add_lead(len, bytes);
            for (int k = 0; k < conts; k++) bytes.insert(bytes.size(), {2'b10, 6'($urandom)});
         end else begin
            bytes.insert(bytes.size(), 8'($urandom));
         end
      end
      foreach (bytes[i]) add_byte(bytes[i], i == bytes.size() - 1, drain && i == 0);
      count = bytes.size();
   endtask

   // block is idle: nothing queued, nothing in flight, pipeline given time to empty
   task automatic settle();
      while (send_q.size() != 0 || req_push || repaired_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_phase(input logic pm, input logic wc, input int send_pct,
                               input int recv_pct, input logic with_drain);
      int total;
      int n;
      int strings;
      settle();
      csr_write(uvr_pkg::CSR_PATH_MODE, pm);
      csr_write(uvr_pkg::CSR_WINDOWS_CHARS, wc);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      total = 0;
      strings = 0;
      while (total < RANDOM_PHASE_WORDS || strings < 2) begin
         add_random_string(with_drain && strings == 1, n);
         total += n;
         strings++;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: plain ascii, complete sequences, broken runs, odd content
      csr_write(uvr_pkg::CSR_PATH_MODE, 1'b0);
      csr_write(uvr_pkg::CSR_WINDOWS_CHARS, 1'b0);
      add_byte(8'h00, 1'b0); add_byte(8'hc3, 1'b0); add_byte(8'ha9, 1'b0);
      add_byte(8'h7f, 1'b1);
      add_byte(8'he2, 1'b0); add_byte(8'h82, 1'b0); add_byte(8'hac, 1'b0);
      add_byte(8'hf0, 1'b0); add_byte(8'h9f, 1'b0); add_byte(8'h98, 1'b0);
      add_byte(8'h80, 1'b1);
      // lead meets ascii, stray continuation, non-lead high byte, end inside sequence
      add_byte(8'hc3, 1'b0); add_byte(8'h41, 1'b0); add_byte(8'h80, 1'b0);
      add_byte(8'hff, 1'b0);
      add_byte(8'he2, 1'b0); add_byte(8'h82, 1'b1);
      // lead as final byte
      add_byte(8'hf0, 1'b1);
      // overlong and out-of-range forms still pass
      add_byte(8'hc0, 1'b0); add_byte(8'h80, 1'b0);
      add_byte(8'hf7, 1'b0); add_byte(8'hbf, 1'b0); add_byte(8'hbf, 1'b0);
      add_byte(8'hbf, 1'b1);

      // directed: path filtering with the windows set
      settle();
      csr_write(uvr_pkg::CSR_PATH_MODE, 1'b1);
      csr_write(uvr_pkg::CSR_WINDOWS_CHARS, 1'b1);
      add_byte(8'h1f, 1'b0); add_byte(8'h3f, 1'b0); add_byte(8'h7f, 1'b1);

      random_phase(1'b1, 1'b0, 0, 0, 1'b0);
      random_phase(1'b0, 1'b1, 79, 0, 1'b1);
      random_phase(1'b1, 1'b1, 0, 79, 1'b0);
      settle();
      csr_write(CSR_SPARE_2, 1'b1);
      csr_write(CSR_SPARE_3, 1'b1);
      random_phase(1'b0, 1'b0, 23, 23, 1'b0);
      random_phase(1'b1, 1'b1, 0, 0, 1'b0);

      settle();
      $display("sent %0d words in %0d strings, checked %0d repaired words, %0d register writes",
               words_in, strings_sent, words_out, csr_writes);
      $display("path mode and windows set swept through all four settings under idle and stall");
      if (mismatches == 0 && repaired_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d words still expected", repaired_q.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
